[hdl/rpar_pkg.sv]
package rpar_pkg;

  localparam int unsigned AngleMax = 19000;
  localparam int unsigned AngleMin = 1200;
  localparam int unsigned PowerScale = 1000;
  localparam logic [16:0] ResReset = 17'd24200;

  // Number of RMS lanes: line and output.
  localparam int unsigned NumLanes = 2;

  typedef enum logic {
    FUNC_MEAS = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  // Input beat, tdata fields from the highest bit down.
  typedef struct packed {
    logic        power_off;
    logic        full_power;
    logic [7:0]  setpoint;
    logic [9:0]  sample_count;
    logic [31:0] sum_sq_out;
    logic [31:0] sum_sq_in;
  } in_data_t;

  // Result beat, tdata fields from the highest bit down.
  typedef struct packed {
    logic        count_error;
    logic [15:0] load_power_watts;
    logic [15:0] firing_angle;
    logic        regulation_ok;
    logic [15:0] output_rms;
    logic [15:0] line_rms;
  } out_data_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

[hdl/rpar_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
module rpar_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [41:0] num_i,
  input  logic [16:0] den_i,
  output logic [41:0] quo_o,
  output logic        done_o
);
  import rpar_pkg::*;

  logic [41:0] quo_q, quo_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[16:0], quo_q[41]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd42;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[40:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[40:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;
endmodule

[hdl/rpar_lane.sv]
// One RMS lane: mean of squares by bit-serial division, then a floor
// square root one result bit per cycle.
module rpar_lane (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] sum_i,
  input  logic [9:0]  count_i,
  output logic [15:0] rms_o,
  output logic        done_o
);
  import rpar_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT
  } state_e;

  state_e      state_q;
  logic [31:0] quo_q;
  logic [10:0] rem_q;
  logic [9:0]  den_q;
  logic [4:0]  cnt_q;
  logic [31:0] v_q;
  logic [31:0] root_q;
  logic [31:0] bit_q;
  logic        done_q;
  logic [10:0] dtrial;
  logic [31:0] rsum;
  logic [31:0] v_cur;

  assign dtrial = {rem_q[9:0], quo_q[31]};
  assign rsum   = root_q + bit_q;
  // The first root step works on the fresh quotient.
  assign v_cur  = (cnt_q == 5'd15) ? quo_q : v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            quo_q   <= sum_i;
            rem_q   <= '0;
            den_q   <= count_i;
            cnt_q   <= 5'd31;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dtrial >= {1'b0, den_q}) begin
            rem_q <= dtrial - {1'b0, den_q};
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= dtrial;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          if (cnt_q == 5'd0) begin
            state_q <= ST_SQRT;
            root_q  <= '0;
            bit_q   <= 32'h4000_0000;
            cnt_q   <= 5'd15;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_SQRT: begin
          if (v_cur >= rsum) begin
            v_q    <= v_cur - rsum;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            v_q    <= v_cur;
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (cnt_q == 5'd0) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rms_o  = root_q[15:0];
  assign done_o = done_q;
endmodule

[hdl/rms_phase_angle_regulator.sv]
// Phase-angle regulator. A regulation tick (tuser high) updates the firing
// angle in ST_TICK and then offers its result from ST_OUT. A measurement
// beat runs both RMS lanes side by side (division, then square root),
// merges them and then runs the power divider before its result is offered;
// a zero sample count skips the lanes and a zero load resistance skips the
// divider. One beat is in work at a time; the next one is accepted the cycle
// after the result beat is taken.
module rms_phase_angle_regulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // sum_sq_in, sum_sq_out, sample_count, setpoint, full_power, power_off, pad
  input  logic [87:0]        s_axis_tdata,
  // func
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // line_rms, output_rms, regulation_ok, firing_angle, load_power_watts,
  // count_error, pad
  output logic [71:0]        m_axis_tdata
);
  import rpar_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANES,
    ST_MERGE,
    ST_POWER,
    ST_TICK,
    ST_OUT
  } state_e;

  state_e      state_q;
  logic [16:0] res_q;
  in_data_t    in_q;
  logic        err_q;
  logic [15:0] line_q, outr_q, angle_q, power_q;
  logic        ok_q;
  logic [NumLanes-1:0] lane_done_q;
  logic        lane_start;
  logic        div_start;
  logic [15:0] lane_rms [NumLanes];
  logic [NumLanes-1:0] lane_done;
  logic [41:0] div_quo;
  logic        div_done;
  logic [15:0] u_sel;
  logic [31:0] u_sq_q;
  logic [41:0] num;
  logic signed [18:0] ang_s;
  in_data_t    in_w;

  assign in_w = in_data_t'(s_axis_tdata[83:0]);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign lane_start = (state_q == ST_IDLE) && s_axis_tvalid
                      && (s_axis_tuser == FUNC_MEAS) && (in_w.sample_count != '0);

  rpar_lane u_lane_line (
    .clk_i, .rst_ni, .start_i(lane_start), .sum_i(in_w.sum_sq_in),
    .count_i(in_w.sample_count), .rms_o(lane_rms[0]), .done_o(lane_done[0])
  );
  rpar_lane u_lane_out (
    .clk_i, .rst_ni, .start_i(lane_start), .sum_i(in_w.sum_sq_out),
    .count_i(in_w.sample_count), .rms_o(lane_rms[1]), .done_o(lane_done[1])
  );

  assign u_sel = in_q.full_power ? line_q : outr_q;
  assign num   = 42'(u_sq_q) * 42'(PowerScale);
  assign div_start = (state_q == ST_MERGE) && (res_q != '0);

  rpar_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(res_q),
    .quo_o(div_quo), .done_o(div_done)
  );

  assign ang_s = 19'(signed'({3'b0, angle_q})) - 19'(signed'({11'b0, in_q.setpoint}))
                 + 19'(signed'({3'b0, outr_q}));

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      in_q <= in_w;
    end
    u_sq_q <= u_sel * u_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= ResReset;
      line_q      <= '0;
      outr_q      <= '0;
      angle_q     <= 16'(AngleMax);
      ok_q        <= 1'b0;
      power_q     <= '0;
      err_q       <= 1'b0;
      lane_done_q <= '0;
    end else begin
      if (cfg_we_i) begin
        res_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == FUNC_TICK) begin
              lane_done_q <= '0;
              err_q       <= 1'b0;
              state_q     <= ST_TICK;
            end else if (in_w.sample_count == '0) begin
              err_q       <= 1'b1;
              state_q     <= ST_LANES;
              lane_done_q <= '1;
            end else begin
              lane_done_q <= '0;
              err_q       <= 1'b0;
              state_q     <= ST_LANES;
            end
          end
        end
        ST_LANES: begin
          lane_done_q <= lane_done_q | lane_done;
          if (lane_done_q == '1) begin
            if (!err_q) begin
              line_q <= lane_rms[0];
              outr_q <= lane_rms[1];
            end
            state_q <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          // u_sq_q reflects the merged RMS values only once lane_done_q is cleared.
          if (lane_done_q == '1) begin
            lane_done_q <= '0;
          end else begin
            ok_q <= ({8'b0, in_q.setpoint} <= line_q);
            if (res_q == '0) begin
              power_q <= 16'hFFFF;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_POWER;
            end
          end
        end
        ST_POWER: begin
          if (div_done) begin
            power_q <= (div_quo[41:16] != '0) ? 16'hFFFF : div_quo[15:0];
            state_q <= ST_OUT;
          end
        end
        ST_TICK: begin
          if (in_q.full_power || in_q.power_off) begin
            angle_q <= 16'(AngleMax);
          end else if (ang_s > signed'(19'(AngleMax))) begin
            angle_q <= 16'(AngleMax);
          end else if (ang_s < signed'(19'(AngleMin))) begin
            angle_q <= 16'(AngleMin);
          end else begin
            angle_q <= ang_s[15:0];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  out_data_t res_w;
  assign res_w = '{count_error: err_q, load_power_watts: power_q,
                   firing_angle: angle_q, regulation_ok: ok_q,
                   output_rms: outr_q, line_rms: line_q};
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {6'b0, res_w};
endmodule
